### hw/rtl/http_request_head_parser_unit_macros.svh
// Assertion macros used by the request head parser checker.
`ifndef HTTP_REQUEST_HEAD_PARSER_UNIT_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define HRHP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define HRHP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/hrhp_pkg.sv
// Types, codes and constants of the request head parser.
`timescale 1ns / 1ps

package hrhp_pkg;

    // Header line limit and the counter width it needs
    localparam int HEADER_LIMIT = 16;
    localparam int HDR_CNT_W    = $clog2(HEADER_LIMIT + 1);
    localparam int BODY_W       = 16;

    // Delimiter characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Byte class codes
    localparam logic [2:0] CL_METHOD  = 3'd0;
    localparam logic [2:0] CL_PATH    = 3'd1;
    localparam logic [2:0] CL_VERSION = 3'd2;
    localparam logic [2:0] CL_NAME    = 3'd3;
    localparam logic [2:0] CL_VALUE   = 3'd4;
    localparam logic [2:0] CL_DELIM   = 3'd5;
    localparam logic [2:0] CL_BODY    = 3'd6;
    localparam logic [2:0] CL_ERROR   = 3'd7;

    // Parse status codes
    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // Parse phases
    typedef enum logic [3:0] {
        PH_METHOD  = 4'd0,
        PH_PATH    = 4'd1,
        PH_VERSION = 4'd2,
        PH_REQ_LF  = 4'd3,
        PH_LINE    = 4'd4,
        PH_NAME    = 4'd5,
        PH_SKIP    = 4'd6,
        PH_VALUE   = 4'd7,
        PH_HDR_LF  = 4'd8,
        PH_BLANK   = 4'd9,
        PH_BODY    = 4'd10
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [3:0]  header_slot;
        logic [1:0]  parse_status;
        logic [4:0]  headers_seen;
        logic [15:0] body_length;
    } t_out_item;

    // Parser state carried from byte to byte
    typedef struct packed {
        t_phase                 phase;
        logic [HDR_CNT_W-1:0]   hdr_cnt;
        logic                   failed;
        logic [BODY_W-1:0]      body_cnt;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:    PH_METHOD,
        hdr_cnt:  '0,
        failed:   1'b0,
        body_cnt: '0
    };

    // Handshake status between the top level and the output register
    typedef struct packed {
        logic load;
        logic can_load;
    } t_ostage_ctl;

endpackage

### hw/rtl/hrhp_step.sv
// Next-state and result logic for one request byte.
`timescale 1ns / 1ps

module hrhp_step (
    input  hrhp_pkg::t_in_item  i_item,
    input  hrhp_pkg::t_state    i_state,
    output hrhp_pkg::t_state    o_state,
    output hrhp_pkg::t_out_item o_result
);

    logic [7:0]             w_b;
    hrhp_pkg::t_state       w_n;
    logic [2:0]             w_cls;
    logic [31:0]            w_cnt_in;
    logic [31:0]            w_cnt_out;
    logic [1:0]             w_status;

    assign w_b      = i_item.data_byte;
    assign w_cnt_in = 32'(i_state.hdr_cnt);

    // Decode the byte against the current phase
    always_comb begin
        w_n   = i_state;
        w_cls = hrhp_pkg::CL_ERROR;
        if (!i_state.failed) begin
            case (i_state.phase)
                hrhp_pkg::PH_METHOD, hrhp_pkg::PH_PATH: begin
                    if (w_b inside {hrhp_pkg::CH_SP, hrhp_pkg::CH_NUL}) begin
                        w_cls     = hrhp_pkg::CL_DELIM;
                        w_n.phase = (i_state.phase == hrhp_pkg::PH_METHOD) ?
                                    hrhp_pkg::PH_PATH : hrhp_pkg::PH_VERSION;
                    end else begin
                        w_cls = (i_state.phase == hrhp_pkg::PH_METHOD) ?
                                hrhp_pkg::CL_METHOD : hrhp_pkg::CL_PATH;
                    end
                end
                hrhp_pkg::PH_VERSION: begin
                    if (w_b inside {hrhp_pkg::CH_CR, hrhp_pkg::CH_NUL}) begin
                        w_cls     = hrhp_pkg::CL_DELIM;
                        w_n.phase = hrhp_pkg::PH_REQ_LF;
                    end else begin
                        w_cls = hrhp_pkg::CL_VERSION;
                    end
                end
                hrhp_pkg::PH_REQ_LF, hrhp_pkg::PH_HDR_LF: begin
                    if (w_b == hrhp_pkg::CH_LF) begin
                        w_cls     = hrhp_pkg::CL_DELIM;
                        w_n.phase = hrhp_pkg::PH_LINE;
                        if (i_state.phase == hrhp_pkg::PH_HDR_LF) begin
                            w_n.hdr_cnt = i_state.hdr_cnt + hrhp_pkg::HDR_CNT_W'(1);
                        end
                    end else begin
                        w_n.failed = 1'b1;
                    end
                end
                hrhp_pkg::PH_LINE, hrhp_pkg::PH_NAME: begin
                    if (i_state.phase == hrhp_pkg::PH_LINE &&
                        w_cnt_in >= 32'(hrhp_pkg::HEADER_LIMIT)) begin
                        w_n.failed = 1'b1;
                    end else if (i_state.phase == hrhp_pkg::PH_LINE &&
                                 w_b == hrhp_pkg::CH_CR) begin
                        w_cls     = hrhp_pkg::CL_DELIM;
                        w_n.phase = hrhp_pkg::PH_BLANK;
                    end else if (w_b inside {hrhp_pkg::CH_COLON, hrhp_pkg::CH_NUL}) begin
                        w_cls     = hrhp_pkg::CL_DELIM;
                        w_n.phase = hrhp_pkg::PH_SKIP;
                    end else begin
                        w_cls     = hrhp_pkg::CL_NAME;
                        w_n.phase = hrhp_pkg::PH_NAME;
                    end
                end
                hrhp_pkg::PH_SKIP, hrhp_pkg::PH_VALUE: begin
                    if (i_state.phase == hrhp_pkg::PH_SKIP && w_b == hrhp_pkg::CH_SP) begin
                        w_cls = hrhp_pkg::CL_DELIM;
                    end else if (w_b inside {hrhp_pkg::CH_CR, hrhp_pkg::CH_NUL}) begin
                        w_cls     = hrhp_pkg::CL_DELIM;
                        w_n.phase = hrhp_pkg::PH_HDR_LF;
                    end else begin
                        w_cls     = hrhp_pkg::CL_VALUE;
                        w_n.phase = hrhp_pkg::PH_VALUE;
                    end
                end
                hrhp_pkg::PH_BLANK: begin
                    if (w_b == hrhp_pkg::CH_NUL) begin
                        w_n.failed = 1'b1;
                    end else begin
                        w_cls     = hrhp_pkg::CL_DELIM;
                        w_n.phase = hrhp_pkg::PH_BODY;
                    end
                end
                hrhp_pkg::PH_BODY: begin
                    w_cls = hrhp_pkg::CL_BODY;
                    if (~&i_state.body_cnt) begin
                        w_n.body_cnt = i_state.body_cnt + hrhp_pkg::BODY_W'(1);
                    end
                end
                default: begin
                    w_n.failed = 1'b1;
                end
            endcase
            if (w_n.failed) begin
                w_cls = hrhp_pkg::CL_ERROR;
            end
        end
    end

    assign w_cnt_out = 32'(w_n.hdr_cnt);

    // Report status on the last byte
    always_comb begin
        w_status = hrhp_pkg::ST_BUSY;
        if (i_item.last_byte) begin
            if (!w_n.failed && (w_n.phase == hrhp_pkg::PH_LINE ||
                                w_n.phase == hrhp_pkg::PH_BODY)) begin
                w_status = hrhp_pkg::ST_ACCEPT;
            end else begin
                w_status = hrhp_pkg::ST_REJECT;
            end
        end
    end

    // Assemble the result; slot uses the count before this byte
    always_comb begin
        o_result.byte_class   = w_cls;
        o_result.header_slot  = (w_cnt_in > 32'd15) ? 4'd15 : w_cnt_in[3:0];
        o_result.parse_status = w_status;
        o_result.headers_seen = (w_cnt_out > 32'd31) ? 5'd31 : w_cnt_out[4:0];
        o_result.body_length  = w_n.body_cnt;
    end

    // Return to the start state after the last byte
    assign o_state = i_item.last_byte ? hrhp_pkg::STATE_RESET : w_n;

endmodule

### hw/rtl/hrhp_out_reg.sv
// Result register with valid/ready handshake toward the receiver.
`timescale 1ns / 1ps

module hrhp_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  hrhp_pkg::t_out_item i_result,
    input  logic                i_out_ready,
    output logic                o_can_load,
    output logic                o_out_valid,
    output hrhp_pkg::t_out_item o_out_item
);

    logic                r_valid;
    logic                n_valid;
    hrhp_pkg::t_out_item r_item;

    // Free when empty or when the held item leaves this cycle
    assign o_can_load = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture the payload on load, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

### hw/rtl/http_request_head_parser_unit.sv
// Top level of the HTTP request head parser.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one request byte
//   per item, with last_byte set on the final byte of the request.
//   Output channel (o_out_valid / i_out_ready / o_out_item) gives one result
//   per byte: byte class, header slot, status, header count and body length.
//   Latency: the result of a byte is valid on the cycle after it is accepted.
//   Throughput: one byte per cycle; the phase decode and counter updates sit
//   between the parse state registers and a single result register.
//   A new byte is taken while the held result is being taken in the same
//   cycle, so a receiver that is always ready sees no bubbles.
//   Receiver stall: the result register holds its item and o_in_ready drops
//   until the item is taken; no byte is dropped.
//   Status is nonzero only on the result of the last byte, after which the
//   parser returns to the method phase for the next request.
//   Reset (synchronous, active low): parser returns to the method phase with
//   all counters cleared and the result register empty; no item is taken
//   while reset is held.

module http_request_head_parser_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hrhp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hrhp_pkg::t_out_item o_out_item
);

    hrhp_pkg::t_state      r_state;
    hrhp_pkg::t_state      n_state;
    hrhp_pkg::t_out_item   w_result;
    hrhp_pkg::t_ostage_ctl w_ctl;
    logic                  w_can_load;

    // Accept a byte when the result register can take its result
    assign w_ctl.can_load = w_can_load;
    assign o_in_ready     = w_ctl.can_load && i_rst_n;
    assign w_ctl.load     = i_in_valid && o_in_ready;

    hrhp_step u_step (
        .i_item   (i_in_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // Advance the parse state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hrhp_pkg::STATE_RESET;
        end else if (w_ctl.load) begin
            r_state <= n_state;
        end
    end

    hrhp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_ctl.load),
        .i_result    (w_result),
        .i_out_ready (i_out_ready),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

### hw/rtl/hrhp_chk.sv
// Port-level checker for the request head parser, bound to the top level.
`timescale 1ns / 1ps
`include "http_request_head_parser_unit_macros.svh"

module hrhp_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input hrhp_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input hrhp_pkg::t_out_item o_out_item
);

    // Stalled result holds
    `HRHP_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "result changed while stalled")

    // Every accepted byte shows its result on the next cycle
    `HRHP_ASSERT(a_latency, i_in_valid && o_in_ready |=> o_out_valid, "result missing after accept")

    // Status is reported on the last byte only
    `HRHP_ASSERT(a_last_status, i_in_valid && o_in_ready |=> (o_out_item.parse_status != hrhp_pkg::ST_BUSY) == $past(i_in_item.last_byte), "status does not match last byte")

    // An empty result register never blocks input
    `HRHP_ASSERT(a_ready_empty, !o_out_valid |-> o_in_ready, "input blocked while output empty")

    // A body byte always carries a nonzero body length
    `HRHP_ASSERT(a_body_len, o_out_valid && o_out_item.byte_class == hrhp_pkg::CL_BODY |-> o_out_item.body_length != 16'd0, "body byte with zero length")

endmodule

bind http_request_head_parser_unit hrhp_chk u_chk (.*);
